// ===== rtl/occ_pkg.sv =====
// Shared types, constants and helper functions for the oven cook cycle controller.
// Used by every module of the block; depends on nothing else.
package occ_pkg;

  // Field widths
  localparam int ADC_W  = 12;
  localparam int DEG_W  = 9;
  localparam int TIME_W = 24;
  localparam int SEL_W  = 2;
  localparam int EVC_W  = 3;

  // Sensor averaging; the group size must be a power of two (1 to 256)
  localparam int SPR       = 16;
  localparam int AVG_SHIFT = $clog2(SPR);
  localparam int SUM_W     = $clog2(SPR * 4095 + 1);
  localparam int CNT_W     = $clog2(SPR + 1);

  // Scaling of an average to degrees: avg * DEG_FULL / 4095
  localparam int PROD_W = 21;
  localparam logic [PROD_W-1:0] DEG_FULL = PROD_W'(330);

  // Event queue between front and back
  localparam int QD   = 4;
  localparam int QA_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  // Raw event codes on the input channel
  localparam logic [EVC_W-1:0] CODE_TICK     = 3'd0;
  localparam logic [EVC_W-1:0] CODE_MODE     = 3'd1;
  localparam logic [EVC_W-1:0] CODE_DONENESS = 3'd2;
  localparam logic [EVC_W-1:0] CODE_START    = 3'd3;
  localparam logic [EVC_W-1:0] CODE_SAMPLE   = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = TIME_W;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BAKE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GRATIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GRILL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_RARE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MEDIUM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WELL     = 3'd5;

  // Selection codes
  localparam logic [SEL_W-1:0] SEL_FIRST = 2'd0;  // bake / rare
  localparam logic [SEL_W-1:0] SEL_MID   = 2'd1;  // gratin / medium
  localparam logic [SEL_W-1:0] SEL_LAST  = 2'd2;  // grill / well done

  // Classified event
  typedef enum logic [2:0] {
    EV_TICK,
    EV_MODE,
    EV_DONENESS,
    EV_START,
    EV_SAMPLE,
    EV_OTHER
  } ev_t;

  typedef struct packed {
    ev_t              ev;
    logic [ADC_W-1:0] smp;
  } occ_item_t;

  // Configuration register set
  typedef struct packed {
    logic [DEG_W-1:0]  target_bake;
    logic [DEG_W-1:0]  target_gratin;
    logic [DEG_W-1:0]  target_grill;
    logic [TIME_W-1:0] time_rare;
    logic [TIME_W-1:0] time_medium;
    logic [TIME_W-1:0] time_well;
  } occ_cfg_t;

  // Cycle through three choices
  function automatic logic [SEL_W-1:0] advance3(input logic [SEL_W-1:0] v);
    advance3 = (v >= SEL_LAST) ? SEL_FIRST : v + SEL_W'(1);
  endfunction

  // Completed group sum to whole degrees. Division by 4095 = 2^12 - 1 is done as
  // (p + (p >> 12) + 1) >> 12, exact for quotients well above 330.
  function automatic logic [DEG_W-1:0] temp_of_sum(input logic [SUM_W-1:0] sum);
    logic [ADC_W-1:0]  avg;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] q;
    avg  = sum[AVG_SHIFT +: ADC_W];
    prod = PROD_W'(avg) * DEG_FULL;
    q    = (prod + (prod >> ADC_W) + PROD_W'(1)) >> ADC_W;
    temp_of_sum = q[DEG_W-1:0];
  endfunction

endpackage

// ===== rtl/occ_front.sv =====
// Front end: accepts input transfers and classifies the event code.
// Depends on occ_pkg.
module occ_front import occ_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [11:0] adc_sample, [15:12] zero
  input  logic [EVC_W-1:0]     in_tuser,   // [2:0] mode (event kind)
  input  logic                 q_full,
  output logic                 q_push,
  output occ_item_t            q_item
);

  ev_t ev;

  // Decode the event code; unused codes pass through as no-ops
  always_comb begin
    unique case (in_tuser)
      CODE_TICK:     ev = EV_TICK;
      CODE_MODE:     ev = EV_MODE;
      CODE_DONENESS: ev = EV_DONENESS;
      CODE_START:    ev = EV_START;
      CODE_SAMPLE:   ev = EV_SAMPLE;
      default:       ev = EV_OTHER;
    endcase
  end

  // Pending-reset guard: no transfer accepted while in reset
  logic rdy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
    end
  end

  assign in_tready  = rdy_r && !q_full;
  assign q_push     = in_tvalid && in_tready;
  assign q_item.ev  = ev;
  assign q_item.smp = in_tdata[ADC_W-1:0];

endmodule

// ===== rtl/occ_fifo.sv =====
// Short event queue between the front end and the execution back end.
// Depends on occ_pkg.
module occ_fifo import occ_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  occ_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output occ_item_t rd_item
);

  occ_item_t       mem_r [QD];
  logic [QA_W-1:0] wp_r;
  logic [QA_W-1:0] rp_r;
  logic [QC_W-1:0] cnt_r;

  assign full    = (cnt_r == QC_W'(QD));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QA_W'(1);
      if (pop)  rp_r <= rp_r + QA_W'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + QC_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QC_W'(1);
      end
    end
  end

endmodule

// ===== rtl/occ_back.sv =====
// Back end: executes queued events against the cook cycle state, then resolves the
// averaged temperature and heater drive in the output register. Depends on occ_pkg.
module occ_back import occ_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  occ_cfg_t    cfg,
  input  logic        q_empty,
  input  occ_item_t   q_item,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  // Control state
  logic [SEL_W-1:0]  next_mode_r, next_mode_nxt;
  logic [SEL_W-1:0]  shown_mode_r, shown_mode_nxt;
  logic [SEL_W-1:0]  next_don_r, next_don_nxt;
  logic [SEL_W-1:0]  shown_don_r, shown_don_nxt;
  logic              busy_r, busy_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Execute-to-output stage
  logic              m_vld_r;
  logic              m_busy_r, m_busy_nxt;
  logic [SEL_W-1:0]  m_smode_r;
  logic [SEL_W-1:0]  m_sdon_r;
  logic              m_done_r, m_done_nxt;
  logic              m_rd_r, m_rd_nxt;
  logic [SUM_W-1:0]  m_sum_r, m_sum_nxt;
  logic [DEG_W-1:0]  m_tgt_r, m_tgt_nxt;

  // Output stage
  logic              o_vld_r;
  logic              heater_r, heater_nxt;
  logic [DEG_W-1:0]  temp_r, temp_nxt;
  logic              o_busy_r;
  logic [SEL_W-1:0]  o_smode_r;
  logic [SEL_W-1:0]  o_sdon_r;
  logic              o_done_r;

  logic              adv;
  logic [SUM_W-1:0]  sum_add;
  logic [CNT_W-1:0]  cnt_add;
  logic [TIME_W-1:0] load_time;

  // Whole pipe moves when the output slot is free or being taken
  assign adv   = !o_vld_r || out_tready;
  assign q_pop = adv && !q_empty;

  assign sum_add = sum_r + SUM_W'(q_item.smp);
  assign cnt_add = cnt_r + CNT_W'(1);

  // Cook time of the shown doneness
  always_comb begin
    unique case (shown_don_r)
      SEL_FIRST: load_time = cfg.time_rare;
      SEL_MID:   load_time = cfg.time_medium;
      default:   load_time = cfg.time_well;
    endcase
  end

  // Target of the shown mode
  always_comb begin
    unique case (shown_mode_r)
      SEL_FIRST: m_tgt_nxt = cfg.target_bake;
      SEL_MID:   m_tgt_nxt = cfg.target_gratin;
      default:   m_tgt_nxt = cfg.target_grill;
    endcase
  end

  // Event execution
  always_comb begin
    next_mode_nxt  = next_mode_r;
    shown_mode_nxt = shown_mode_r;
    next_don_nxt   = next_don_r;
    shown_don_nxt  = shown_don_r;
    busy_nxt       = busy_r;
    rem_nxt        = rem_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    m_done_nxt     = 1'b0;
    m_rd_nxt       = 1'b0;
    m_sum_nxt      = sum_add;
    unique case (q_item.ev)
      EV_TICK: begin
        if (busy_r) begin
          if (rem_r <= TIME_W'(1)) begin
            rem_nxt    = '0;
            busy_nxt   = 1'b0;
            m_done_nxt = 1'b1;
          end else begin
            rem_nxt = rem_r - TIME_W'(1);
          end
        end
      end
      EV_MODE: begin
        if (!busy_r) begin
          shown_mode_nxt = next_mode_r;
          next_mode_nxt  = advance3(next_mode_r);
        end
      end
      EV_DONENESS: begin
        if (!busy_r) begin
          shown_don_nxt = next_don_r;
          next_don_nxt  = advance3(next_don_r);
        end
      end
      EV_START: begin
        if (!busy_r) begin
          busy_nxt = 1'b1;
          rem_nxt  = load_time;
          sum_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      EV_SAMPLE: begin
        if (busy_r) begin
          if (cnt_add >= CNT_W'(SPR)) begin
            m_rd_nxt = 1'b1;
            sum_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            sum_nxt = sum_add;
            cnt_nxt = cnt_add;
          end
        end
      end
      default: begin
      end
    endcase
    m_busy_nxt = busy_nxt;
  end

  // Control state and execute stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_mode_r  <= SEL_FIRST;
      shown_mode_r <= SEL_FIRST;
      next_don_r   <= SEL_FIRST;
      shown_don_r  <= SEL_FIRST;
      busy_r       <= 1'b0;
      rem_r        <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      m_vld_r      <= 1'b0;
    end else if (adv) begin
      m_vld_r <= q_pop;
      if (q_pop) begin
        next_mode_r  <= next_mode_nxt;
        shown_mode_r <= shown_mode_nxt;
        next_don_r   <= next_don_nxt;
        shown_don_r  <= shown_don_nxt;
        busy_r       <= busy_nxt;
        rem_r        <= rem_nxt;
        sum_r        <= sum_nxt;
        cnt_r        <= cnt_nxt;
      end
    end
  end

  // Execute stage payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_busy_r  <= m_busy_nxt;
      m_smode_r <= shown_mode_nxt;
      m_sdon_r  <= shown_don_nxt;
      m_done_r  <= m_done_nxt;
      m_rd_r    <= m_rd_nxt;
      m_sum_r   <= m_sum_nxt;
      m_tgt_r   <= m_tgt_nxt;
    end
  end

  // Temperature and heater resolution
  always_comb begin
    heater_nxt = heater_r;
    temp_nxt   = temp_r;
    if (m_rd_r) begin
      temp_nxt   = temp_of_sum(m_sum_r);
      heater_nxt = !(temp_nxt > m_tgt_r);
    end else if (m_done_r) begin
      heater_nxt = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r  <= 1'b0;
      heater_r <= 1'b0;
      temp_r   <= '0;
    end else if (adv) begin
      o_vld_r <= m_vld_r;
      if (m_vld_r) begin
        heater_r <= heater_nxt;
        temp_r   <= temp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m_vld_r) begin
      o_busy_r  <= m_busy_r;
      o_smode_r <= m_smode_r;
      o_sdon_r  <= m_sdon_r;
      o_done_r  <= m_done_r;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {o_done_r, temp_r, o_sdon_r, o_smode_r, o_busy_r, heater_r};

endmodule

// ===== rtl/oven_cook_cycle_controller_top.sv =====
// Oven cook cycle controller: one event per input transfer (1 ms tick, mode button,
// doneness button, start, sensor sample), one status transfer out per event. The
// front end classifies events into a four-entry queue; the back end executes them
// and resolves averaged temperature and heater drive. One event is accepted per
// clock when the output side keeps up; an event's status passes through the queue
// write, the execute stage and the output register on its way out. With the output
// stalled, six events are held before in_tready drops. Configuration registers are
// to be written through the cfg port only while no event is in flight; the user is
// bound by this, and the block itself does not enforce it.
// Depends on occ_pkg, occ_front, occ_fifo and occ_back.
module oven_cook_cycle_controller_top import occ_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Event input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [11:0] adc_sample, [15:12] zero
  input  logic [EVC_W-1:0]     in_tuser,   // [2:0] mode (event kind)
  // Status output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [0] heater_on, [1] cooking,
                                           // [3:2] selected_mode,
                                           // [5:4] selected_doneness,
                                           // [14:6] temperature, [15] cycle_done
  // Configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  occ_cfg_t  cfg_r;
  logic      q_full;
  logic      q_push;
  logic      q_empty;
  logic      q_pop;
  occ_item_t q_wr_item;
  occ_item_t q_rd_item;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_bake   <= DEG_W'(180);
      cfg_r.target_gratin <= DEG_W'(220);
      cfg_r.target_grill  <= DEG_W'(250);
      cfg_r.time_rare     <= TIME_W'(60000);
      cfg_r.time_medium   <= TIME_W'(120000);
      cfg_r.time_well     <= TIME_W'(180000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_BAKE:   cfg_r.target_bake   <= cfg_wdata[DEG_W-1:0];
        REG_TARGET_GRATIN: cfg_r.target_gratin <= cfg_wdata[DEG_W-1:0];
        REG_TARGET_GRILL:  cfg_r.target_grill  <= cfg_wdata[DEG_W-1:0];
        REG_TIME_RARE:     cfg_r.time_rare     <= cfg_wdata[TIME_W-1:0];
        REG_TIME_MEDIUM:   cfg_r.time_medium   <= cfg_wdata[TIME_W-1:0];
        REG_TIME_WELL:     cfg_r.time_well     <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  occ_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  occ_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_item (q_rd_item)
  );

  occ_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
